// File: rtl/core/atp_pkg.sv
// Shared constants, types and angle table for the accelerometer tilt block.
`timescale 1ns / 1ps
`default_nettype none

package atp_pkg;

   // Sample and step configuration
   localparam int SAMPLE_BITS  = 16;
   localparam int CORDIC_STEPS = 16;
   localparam int TABLE_LEN    = 24;
   localparam int NUM_ROT      = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
   localparam int STEP_W       = $clog2(TABLE_LEN);

   // Fixed-point scaling: vectors carry 8 fraction bits, angles 1/65536 degree
   localparam int FRAC_SHIFT   = 8;
   localparam int ROUND_BIAS   = 1 << (FRAC_SHIFT - 1);
   localparam int SQ_W         = 2 * SAMPLE_BITS;
   localparam int ROOT_W       = SAMPLE_BITS + FRAC_SHIFT;
   localparam int RAD_W        = 2 * ROOT_W;
   localparam int REM_W        = ROOT_W + 2;
   localparam int VEC_W        = SAMPLE_BITS + FRAC_SHIFT + 3;
   localparam int ACC_W        = 26;
   localparam int ANGLE_W      = 22;

   // Result formats and limits (1/256 degree)
   localparam int PITCH_W      = 16;
   localparam int ROLL_W       = 17;
   localparam int ROLL_LIMIT   = 46080;
   localparam int PITCH_LIMIT  = 23040;

   // Turn constants in accumulator units
   localparam int HALF_TURN_DEG = 180;
   localparam logic signed [ACC_W-1:0] HALF_TURN    = ACC_W'(HALF_TURN_DEG * 65536);
   localparam logic signed [ACC_W-1:0] QUARTER_TURN = ACC_W'(HALF_TURN_DEG * 65536 / 2);

   // atan(2^-i) in 1/65536 degree
   localparam logic [ANGLE_W-1:0] STEP_ANGLE [TABLE_LEN] = '{
      22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
      22'd234379,  22'd117305,  22'd58666,  22'd29335,
      22'd14668,   22'd7334,    22'd3667,   22'd1833,
      22'd917,     22'd458,     22'd229,    22'd115,
      22'd57,      22'd29,      22'd14,     22'd7,
      22'd4,       22'd2,       22'd1,      22'd0
   };

   // One vectoring lane: vector, angle accumulator, and a bypass for fixed answers
   typedef struct packed {
      logic signed [VEC_W-1:0] px;
      logic signed [VEC_W-1:0] py;
      logic signed [ACC_W-1:0] acc;
      logic                    hold;
   } lane_type;

   // Digit-by-digit square root state
   typedef struct packed {
      logic [RAD_W-1:0]  rad;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } sqrt_type;

   // Data riding alongside the square root
   typedef struct packed {
      lane_type                roll;
      logic signed [VEC_W-1:0] nx;
      logic                    nx_zero;
      logic                    yz_zero;
   } side_type;

   // Both angle lanes through the rotation chain
   typedef struct packed {
      lane_type roll;
      lane_type pitch;
   } pair_type;

endpackage

`default_nettype wire

// File: rtl/core/accel_tilt_pitch_roll.sv
// Top level: tilt angles (pitch, roll) from a three-axis accelerometer sample.
//
// Input channel req_*: one transaction carries accel_x/y/z, signed raw counts.
// Result channel rsp_*: one transaction per sample, pitch and roll in 1/256 degree;
// roll = atan2(y, z) in -180..+180 degrees, pitch = atan2(-x, |(y, z)|) in -90..+90.
// Both channels use valid/ready; a transaction moves when both are high.
//
// Pipeline: one input cell (squares, quadrant setup), 24 square-root cells
// (one root bit each, SAMPLE_BITS + 8 in all), 16 rotation cells (CORDIC_STEPS
// micro-rotations for both angles side by side), and an output register that
// rounds and saturates. Throughput is one sample per clock while rsp_ready
// stays high: each cell holds one sample.
//
// Every cell has its own valid bit and ready flows backward cell by cell, so
// while the receiver stalls the result holds in the output register and samples
// behind it keep moving into empty cells; req_ready drops only during reset or once
// the whole chain is full. Synchronous reset empties every cell; no data is kept.
`timescale 1ns / 1ps
`default_nettype none

module accel_tilt_pitch_roll (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [atp_pkg::SAMPLE_BITS-1:0] req_accel_x,
   input  logic signed [atp_pkg::SAMPLE_BITS-1:0] req_accel_y,
   input  logic signed [atp_pkg::SAMPLE_BITS-1:0] req_accel_z,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [atp_pkg::PITCH_W-1:0]    rsp_pitch_angle,
   output logic signed [atp_pkg::ROLL_W-1:0]     rsp_roll_angle
);
   import atp_pkg::*;

   localparam int OUT_W = ACC_W + 1 - FRAC_SHIFT;

   logic                       front_ready;
   logic                       sq_valid [ROOT_W+1];
   logic                       sq_ready [ROOT_W+1];
   sqrt_type                   sq_state [ROOT_W+1];
   side_type                   sq_side  [ROOT_W+1];
   logic                       cr_valid [NUM_ROT+1];
   logic                       cr_ready [NUM_ROT+1];
   pair_type                   cr_data  [NUM_ROT+1];
   pair_type                   join_data;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic signed [PITCH_W-1:0]  pitch_ff;
   logic signed [ROLL_W-1:0]   roll_ff;
   logic                       out_load;

   // Round half up to 1/256 degree and clamp to the legal range
   function automatic logic signed [OUT_W-1:0] round_sat(
      input logic signed [ACC_W-1:0] acc,
      input int                      limit
   );
      logic signed [ACC_W:0]   biased;
      logic signed [OUT_W-1:0] v;
      logic signed [OUT_W-1:0] lim;
      biased = $signed({acc[ACC_W-1], acc}) + $signed((ACC_W + 1)'(ROUND_BIAS));
      v      = OUT_W'(biased >>> FRAC_SHIFT);
      lim    = OUT_W'(limit);
      if (v > lim) begin
         v = lim;
      end
      if (v < -lim) begin
         v = -lim;
      end
      return v;
   endfunction

   // Input cell
   assign req_ready = front_ready && !reset;

   atp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (front_ready),
      .accel_x   (req_accel_x),
      .accel_y   (req_accel_y),
      .accel_z   (req_accel_z),
      .out_valid (sq_valid[0]),
      .out_ready (sq_ready[0]),
      .out_sqrt  (sq_state[0]),
      .out_side  (sq_side[0])
   );

   // Square-root chain, one root bit per cell
   for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
      atp_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (sq_valid[k]),
         .in_ready  (sq_ready[k]),
         .in_sqrt   (sq_state[k]),
         .in_side   (sq_side[k]),
         .out_valid (sq_valid[k+1]),
         .out_ready (sq_ready[k+1]),
         .out_sqrt  (sq_state[k+1]),
         .out_side  (sq_side[k+1])
      );
   end

   // Pitch lane setup from the magnitude and -x
   always_comb begin
      join_data.roll       = sq_side[ROOT_W].roll;
      join_data.pitch.px   = $signed(VEC_W'(sq_state[ROOT_W].root));
      join_data.pitch.py   = sq_side[ROOT_W].nx;
      join_data.pitch.acc  = '0;
      join_data.pitch.hold = 1'b0;
      if (sq_side[ROOT_W].nx_zero) begin
         join_data.pitch.hold = 1'b1;
      end else if (sq_side[ROOT_W].yz_zero) begin
         // no magnitude: straight up or down
         join_data.pitch.hold = 1'b1;
         join_data.pitch.acc  = sq_side[ROOT_W].nx[VEC_W-1] ? -QUARTER_TURN : QUARTER_TURN;
      end
   end

   assign cr_valid[0]      = sq_valid[ROOT_W];
   assign sq_ready[ROOT_W] = cr_ready[0];
   assign cr_data[0]       = join_data;

   // Rotation chain
   for (genvar i = 0; i < NUM_ROT; i++) begin : g_rot
      atp_cordic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .step_idx  (STEP_W'(i)),
         .in_valid  (cr_valid[i]),
         .in_ready  (cr_ready[i]),
         .in_data   (cr_data[i]),
         .out_valid (cr_valid[i+1]),
         .out_ready (cr_ready[i+1]),
         .out_data  (cr_data[i+1])
      );
   end

   // Output register
   assign cr_ready[NUM_ROT] = !rsp_valid_ff || rsp_ready;
   assign out_load          = cr_valid[NUM_ROT] && cr_ready[NUM_ROT];
   assign rsp_valid_in      = cr_ready[NUM_ROT] ? cr_valid[NUM_ROT] : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         pitch_ff <= PITCH_W'(round_sat(cr_data[NUM_ROT].pitch.acc, PITCH_LIMIT));
         roll_ff  <= ROLL_W'(round_sat(cr_data[NUM_ROT].roll.acc, ROLL_LIMIT));
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pitch_angle = pitch_ff;
   assign rsp_roll_angle  = roll_ff;

   // An accepted sample always lands in the input cell
   a_front_load: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> sq_valid[0])
      else $error("accepted sample missing from input cell");

   // A new result only appears after a load from the rotation chain
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cr_valid[NUM_ROT] && cr_ready[NUM_ROT]))
      else $error("result appeared without a load");

   // Root and side data stay aligned: zero root exactly for a zero (y, z) sample
   a_root_align: assert property (@(posedge clock) disable iff (reset)
      sq_valid[ROOT_W] |-> ((sq_state[ROOT_W].root == '0) == sq_side[ROOT_W].yz_zero))
      else $error("square root and side data out of step");

endmodule

`default_nettype wire

// File: rtl/core/atp_front.sv
// Input stage: squares of y and z, roll quadrant setup, scaled -x.
`timescale 1ns / 1ps
`default_nettype none

module atp_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  logic signed [atp_pkg::SAMPLE_BITS-1:0] accel_x,
   input  logic signed [atp_pkg::SAMPLE_BITS-1:0] accel_y,
   input  logic signed [atp_pkg::SAMPLE_BITS-1:0] accel_z,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output atp_pkg::sqrt_type                     out_sqrt,
   output atp_pkg::side_type                     out_side
);
   import atp_pkg::*;

   logic                    valid_ff;
   logic                    valid_in;
   sqrt_type                sqrt_ff;
   sqrt_type                sqrt_in;
   side_type                side_ff;
   side_type                side_in;
   logic signed [SQ_W-1:0]  y_sq;
   logic signed [SQ_W-1:0]  z_sq;
   logic [SQ_W-1:0]         sq_sum;
   logic signed [VEC_W-1:0] xs;
   logic signed [VEC_W-1:0] ys;
   logic signed [VEC_W-1:0] zs;

   // Radicand (y^2 + z^2) * 2^16
   always_comb begin
      y_sq = SQ_W'(accel_y) * SQ_W'(accel_y);
      z_sq = SQ_W'(accel_z) * SQ_W'(accel_z);
      sq_sum = $unsigned(y_sq) + $unsigned(z_sq);
      sqrt_in.rad  = {sq_sum, {(2 * FRAC_SHIFT){1'b0}}};
      sqrt_in.rem  = '0;
      sqrt_in.root = '0;
   end

   // Roll quadrant handling and pitch ordinate
   always_comb begin
      xs = VEC_W'(accel_x) <<< FRAC_SHIFT;
      ys = VEC_W'(accel_y) <<< FRAC_SHIFT;
      zs = VEC_W'(accel_z) <<< FRAC_SHIFT;
      side_in.roll.px   = zs;
      side_in.roll.py   = ys;
      side_in.roll.acc  = '0;
      side_in.roll.hold = 1'b0;
      if (accel_y == '0) begin
         // on the z axis: zero or half turn
         side_in.roll.hold = 1'b1;
         side_in.roll.acc  = accel_z[SAMPLE_BITS-1] ? HALF_TURN : '0;
      end else if (accel_z == '0) begin
         side_in.roll.hold = 1'b1;
         side_in.roll.acc  = accel_y[SAMPLE_BITS-1] ? -QUARTER_TURN : QUARTER_TURN;
      end else if (accel_z[SAMPLE_BITS-1]) begin
         // left half plane: take a half turn, then rotate the mirrored vector
         side_in.roll.acc = accel_y[SAMPLE_BITS-1] ? -HALF_TURN : HALF_TURN;
         side_in.roll.px  = -zs;
         side_in.roll.py  = -ys;
      end
      side_in.nx      = -xs;
      side_in.nx_zero = (accel_x == '0);
      side_in.yz_zero = (accel_y == '0) && (accel_z == '0);
   end

   // Handshake
   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_sqrt  = sqrt_ff;
   assign out_side  = side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         sqrt_ff <= sqrt_in;
         side_ff <= side_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/atp_sqrt_cell.sv
// One root digit of the pipelined square root, with side data carried along.
`timescale 1ns / 1ps
`default_nettype none

module atp_sqrt_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  atp_pkg::sqrt_type in_sqrt,
   input  atp_pkg::side_type in_side,
   output logic              out_valid,
   input  logic              out_ready,
   output atp_pkg::sqrt_type out_sqrt,
   output atp_pkg::side_type out_side
);
   import atp_pkg::*;

   logic             valid_ff;
   logic             valid_in;
   sqrt_type         sqrt_ff;
   sqrt_type         sqrt_in;
   side_type         side_ff;
   logic [REM_W+1:0] rem2;
   logic [REM_W+1:0] trial;
   logic [REM_W+1:0] diff;
   logic             take;

   // Bring down two radicand bits, try (root*4 + 1)
   always_comb begin
      rem2  = {in_sqrt.rem, in_sqrt.rad[RAD_W-1 -: 2]};
      trial = (REM_W + 2)'({in_sqrt.root, 2'b01});
      diff  = rem2 - trial;
      take  = (rem2 >= trial);
      sqrt_in.rem  = take ? diff[REM_W-1:0] : rem2[REM_W-1:0];
      sqrt_in.root = {in_sqrt.root[ROOT_W-2:0], take};
      sqrt_in.rad  = {in_sqrt.rad[RAD_W-3:0], 2'b00};
   end

   // Handshake
   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_sqrt  = sqrt_ff;
   assign out_side  = side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         sqrt_ff <= sqrt_in;
         side_ff <= in_side;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/atp_cordic_cell.sv
// One vectoring micro-rotation, applied to both the roll and pitch lanes.
`timescale 1ns / 1ps
`default_nettype none

module atp_cordic_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [atp_pkg::STEP_W-1:0]  step_idx,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  atp_pkg::pair_type           in_data,
   output logic                        out_valid,
   input  logic                        out_ready,
   output atp_pkg::pair_type           out_data
);
   import atp_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   pair_type data_ff;
   pair_type data_in;

   // Drive py toward zero; fixed-answer lanes pass untouched
   function automatic lane_type rotate(input lane_type l, input logic [STEP_W-1:0] i);
      lane_type                r;
      logic signed [VEC_W-1:0] dx;
      logic signed [VEC_W-1:0] dy;
      logic signed [ACC_W-1:0] ang;
      r   = l;
      dx  = $signed(l.py) >>> i;
      dy  = $signed(l.px) >>> i;
      ang = $signed(ACC_W'(STEP_ANGLE[i]));
      if (!l.hold) begin
         if (l.py[VEC_W-1]) begin
            r.px  = l.px - dx;
            r.py  = l.py + dy;
            r.acc = l.acc - ang;
         end else begin
            r.px  = l.px + dx;
            r.py  = l.py - dy;
            r.acc = l.acc + ang;
         end
      end
      return r;
   endfunction

   always_comb begin
      data_in.roll  = rotate(in_data.roll, step_idx);
      data_in.pitch = rotate(in_data.pitch, step_idx);
   end

   // Handshake
   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire
